[design/qvc_pkg.sv]
// shared types and constants for the quic varint codec
`timescale 1ns / 1ps
`default_nettype none

package qvc_pkg;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_ERROR = 2'd2
  } result_kind_e;

  // two-bit length tags carried in the top of a first byte
  localparam logic [1:0] TAG_LEN1 = 2'd0;
  localparam logic [1:0] TAG_LEN2 = 2'd1;
  localparam logic [1:0] TAG_LEN4 = 2'd2;
  localparam logic [1:0] TAG_LEN8 = 2'd3;

  localparam logic [7:0] LOW_SIX_MASK = 8'h3F;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   byte_out;
    logic [61:0]  value_out;
    logic [3:0]   encoded_length;
    logic         last;
  } result_t;

endpackage

`default_nettype wire

[design/qvc_if.sv]
// valid/ready channels for input items and result words
`timescale 1ns / 1ps
`default_nettype none

interface qvc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  byte_in;
  logic [63:0] value_in;

  modport source (output valid, output opcode, output byte_in, output value_in,
                  input ready);
  modport sink   (input valid, input opcode, input byte_in, input value_in,
                  output ready);
endinterface

interface qvc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  byte_out;
  logic [61:0] value_out;
  logic [3:0]  encoded_length;
  logic        last;

  modport source (output valid, output result_kind, output byte_out, output value_out,
                  output encoded_length, output last, input ready);
  modport sink   (input valid, input result_kind, input byte_out, input value_out,
                  input encoded_length, input last, output ready);
endinterface

`default_nettype wire

[design/qvc_decoder.sv]
// decode state and one-byte accumulation step
`timescale 1ns / 1ps
`default_nettype none

module qvc_decoder (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      byte_i,
  output qvc_pkg::result_t     res_o,
  output logic                 has_result_o
);
  import qvc_pkg::*;

  logic [2:0]  remain_q, remain_d;
  logic [61:0] acc_q, acc_d;
  logic [3:0]  len_q, len_d;

  always_comb begin
    if (remain_q == 3'd0) begin
      len_d    = 4'd1 << byte_i[7:6];
      acc_d    = {56'd0, byte_i[5:0] & LOW_SIX_MASK[5:0]};
      remain_d = 3'(len_d - 4'd1);
    end else begin
      len_d    = len_q;
      acc_d    = {acc_q[53:0], byte_i};
      remain_d = remain_q - 3'd1;
    end
    has_result_o         = (remain_d == 3'd0);
    res_o.kind           = KIND_VALUE;
    res_o.byte_out       = 8'd0;
    res_o.value_out      = acc_d;
    res_o.encoded_length = len_d;
    res_o.last           = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= 3'd0;
      acc_q    <= 62'd0;
      len_q    <= 4'd0;
    end else if (step_i) begin
      remain_q <= remain_d;
      acc_q    <= acc_d;
      len_q    <= len_d;
    end
  end

endmodule

`default_nettype wire

[design/qvc_encoder.sv]
// length class and byte selection for one encoded word
`timescale 1ns / 1ps
`default_nettype none

module qvc_encoder (
  input  wire logic [63:0]     value_i,
  input  wire logic [2:0]      idx_i,
  output qvc_pkg::result_t     res_o
);
  import qvc_pkg::*;

  logic [1:0] tag;
  logic [2:0] len_m1;
  logic [2:0] pos;
  logic [7:0] sel_byte;
  logic       too_big;

  always_comb begin
    too_big = (value_i[63:62] != 2'b00);
    if (value_i[61:6] == 56'd0) begin
      tag = TAG_LEN1;
    end else if (value_i[61:14] == 48'd0) begin
      tag = TAG_LEN2;
    end else if (value_i[61:30] == 32'd0) begin
      tag = TAG_LEN4;
    end else begin
      tag = TAG_LEN8;
    end
    len_m1   = 3'((4'd1 << tag) - 4'd1);
    // most significant byte goes out first
    pos      = len_m1 - idx_i;
    sel_byte = value_i[{pos, 3'b000} +: 8];
    if (idx_i == 3'd0) begin
      sel_byte = sel_byte | {tag, 6'd0};
    end

    if (too_big) begin
      res_o.kind           = KIND_ERROR;
      res_o.byte_out       = 8'd0;
      res_o.encoded_length = 4'd0;
      res_o.last           = 1'b1;
    end else begin
      res_o.kind           = KIND_BYTE;
      res_o.byte_out       = sel_byte;
      res_o.encoded_length = 4'd1 << tag;
      res_o.last           = (idx_i == len_m1);
    end
    res_o.value_out = 62'd0;
  end

endmodule

`default_nettype wire

[design/quic_varint_codec_unit.sv]
// top level of the quic variable-length integer codec
//
//   channel  dir  word
//   in_i     in   opcode, byte_in, value_in
//   out_o    out  result_kind, byte_out, value_out, encoded_length, last
//
// an input word sits in the input register; a decode word leaves it unless its
// value waits on a stalled result register, an encode word after 1, 2, 4 or 8
// output words, one per cycle while not stalled; a new input word is taken in
// the cycle the held one finishes; the result register holds a word until
// out_o.ready; a full, stalled result register stops the input register and
// through it in_i.ready; reset clears decode state, valid flags and byte index
`timescale 1ns / 1ps
`default_nettype none

module quic_varint_codec_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qvc_in_if.sink     in_i,
  qvc_out_if.source  out_o
);
  import qvc_pkg::*;

  logic        in_valid_q;
  logic        op_q;
  logic [7:0]  byte_q;
  logic [63:0] value_q;
  logic [2:0]  idx_q, idx_d;

  logic        out_valid_q;
  result_t     out_q;

  result_t     dec_res, enc_res, sel_res;
  logic        dec_has;
  logic        out_free;
  logic        emit;
  logic        consume;
  logic        dec_step;

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    emit    = 1'b0;
    consume = 1'b0;
    sel_res = enc_res;
    idx_d   = idx_q;
    if (in_valid_q) begin
      if (op_q == OP_DECODE) begin
        sel_res = dec_res;
        emit    = dec_has && out_free;
        // a mid-run byte yields nothing and never waits on the output
        consume = !dec_has || out_free;
      end else if (out_free) begin
        emit    = 1'b1;
        consume = enc_res.last;
        idx_d   = enc_res.last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  assign dec_step   = in_valid_q && (op_q == OP_DECODE) && consume;
  assign in_i.ready = !in_valid_q || consume;

  qvc_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (dec_step),
    .byte_i       (byte_q),
    .res_o        (dec_res),
    .has_result_o (dec_has)
  );

  qvc_encoder u_encoder (
    .value_i (value_q),
    .idx_i   (idx_q),
    .res_o   (enc_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      idx_q <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      op_q    <= in_i.opcode;
      byte_q  <= in_i.byte_in;
      value_q <= in_i.value_in;
    end
    if (emit) begin
      out_q <= sel_res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_kind    = out_q.kind;
  assign out_o.byte_out       = out_q.byte_out;
  assign out_o.value_out      = out_q.value_out;
  assign out_o.encoded_length = out_q.encoded_length;
  assign out_o.last           = out_q.last;

`ifndef NO_ASSERTIONS
  // a nonzero byte index only exists while an encode word is held
  a_idx_encode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 3'd0) |-> (in_valid_q && op_q == OP_ENCODE))
    else $error("byte index set without a held encode word");

  // an empty input register always takes a word
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_i.ready)
    else $error("input stalled while input register empty");

  // a result never overwrites a stalled result word
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !emit)
    else $error("result register overwritten while stalled");

  // decoded values and errors are single-word results
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind != KIND_BYTE) |-> out_q.last)
    else $error("value or error result without last");

  // an encode word advances its byte index whenever it emits a non-final byte
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && op_q == OP_ENCODE && !enc_res.last) |=> (idx_q == $past(idx_q) + 3'd1))
    else $error("byte index did not advance");
`endif

endmodule

`default_nettype wire

[bench/varint_checker.sv]
// checker for the quic varint codec: watches both channels, predicts and compares result words
`timescale 1ns / 1ps

module varint_checker (
  input  logic clk_i,
  input  logic rst_ni,
  qvc_in_if    in_mon_i,
  qvc_out_if   out_mon_i,
  output int   fail_count_o,
  output int   pending_o
);
  import qvc_pkg::*;

  localparam int PRINT_LIMIT = 40;

  result_t     expected_words [$];
  logic [2:0]  run_bytes_left;
  logic [61:0] run_acc;
  logic [3:0]  run_len;
  int          fail_total = 0;

  assign fail_count_o = fail_total;

  task automatic report_mismatch(input string what);
    if (fail_total < PRINT_LIMIT) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
    fail_total++;
  endtask

  task automatic push_decoded();
    result_t w;
    w.kind           = KIND_VALUE;
    w.byte_out       = '0;
    w.value_out      = run_acc;
    w.encoded_length = run_len;
    w.last           = 1'b1;
    expected_words.push_back(w);
  endtask

  task automatic predict_decode(input logic [7:0] b);
    if (run_bytes_left == 3'd0) begin
      // first byte: tag picks the run length, low six bits seed the value
      run_len = 4'd1 << b[7:6];
      run_acc = {56'd0, b[5:0]};
      if (b[7:6] == TAG_LEN1) begin
        push_decoded();
      end else begin
        run_bytes_left = run_len[2:0] - 3'd1;
      end
    end else begin
      run_acc        = {run_acc[53:0], b};
      run_bytes_left = run_bytes_left - 3'd1;
      if (run_bytes_left == 3'd0) begin
        push_decoded();
      end
    end
  endtask

  task automatic predict_encode(input logic [63:0] v);
    result_t     w;
    logic [1:0]  tag;
    logic [3:0]  len;
    logic [63:0] shifted;
    w.value_out = '0;
    if (v[63:62] != 2'b00) begin
      w.kind           = KIND_ERROR;
      w.byte_out       = '0;
      w.encoded_length = '0;
      w.last           = 1'b1;
      expected_words.push_back(w);
    end else begin
      if (v < 64'h40) begin
        tag = TAG_LEN1;
      end else if (v < 64'h4000) begin
        tag = TAG_LEN2;
      end else if (v < 64'h4000_0000) begin
        tag = TAG_LEN4;
      end else begin
        tag = TAG_LEN8;
      end
      len = 4'd1 << tag;
      for (int i = 0; i < len; i++) begin
        shifted          = v >> (8 * (len - 1 - i));
        w.kind           = KIND_BYTE;
        w.byte_out       = shifted[7:0];
        if (i == 0) begin
          w.byte_out = w.byte_out | {tag, 6'd0};
        end
        w.encoded_length = len;
        w.last           = (i == len - 1);
        expected_words.push_back(w);
      end
    end
  endtask

  always @(posedge clk_i) begin
    result_t exp;
    if (!rst_ni) begin
      expected_words.delete();
      run_bytes_left = '0;
      run_acc        = '0;
      run_len        = '0;
      pending_o     <= 0;
    end else begin
      // inputs first, in case a result could leave in the cycle its cause arrives
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (in_mon_i.opcode == OP_ENCODE) begin
          predict_encode(in_mon_i.value_in);
        end else begin
          predict_decode(in_mon_i.byte_in);
        end
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected: kind %0d byte %h value %h",
                                    out_mon_i.result_kind, out_mon_i.byte_out,
                                    out_mon_i.value_out));
        end else begin
          exp = expected_words.pop_front();
          if (out_mon_i.result_kind !== exp.kind)
            report_mismatch($sformatf("result_kind got %0d want %0d",
                                      out_mon_i.result_kind, exp.kind));
          if (out_mon_i.byte_out !== exp.byte_out)
            report_mismatch($sformatf("byte_out got %h want %h",
                                      out_mon_i.byte_out, exp.byte_out));
          if (out_mon_i.value_out !== exp.value_out)
            report_mismatch($sformatf("value_out got %h want %h",
                                      out_mon_i.value_out, exp.value_out));
          if (out_mon_i.encoded_length !== exp.encoded_length)
            report_mismatch($sformatf("encoded_length got %0d want %0d",
                                      out_mon_i.encoded_length, exp.encoded_length));
          if (out_mon_i.last !== exp.last)
            report_mismatch($sformatf("last got %b want %b", out_mon_i.last, exp.last));
        end
      end
      pending_o <= expected_words.size();
    end
  end

endmodule

[bench/testbench.sv]
// top of the quic varint codec bench: clock, reset, stimulus, receiver, watchdog and verdict
`timescale 1ns / 1ps

module testbench;
  import qvc_pkg::*;

  localparam int RESET_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 20;
  localparam int PHASE_ITEMS    = 100;

  logic clk_i        = 1'b0;
  logic rst_ni       = 1'b0;
  logic result_ready = 1'b0;
  logic hold_go      = 1'b0;
  int   hold_left    = 0;
  int   idle_pct     = 0;
  int   stall_pct    = 0;
  int   items_sent   = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   results_pending;

  qvc_in_if  in_ch ();
  qvc_out_if out_ch ();

  assign out_ch.ready = result_ready;

  quic_varint_codec_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  varint_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  always #2 clk_i = ~clk_i;

  // receiver: random stalls, or a long hold-off when asked for
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_go) begin
      result_ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ends the run when no word moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(input opcode_e op, input logic [7:0] b, input logic [63:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.byte_in  <= b;
    in_ch.value_in <= v;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(OP_DECODE, b, {$urandom(), $urandom()});
  endtask

  task automatic send_value(input logic [63:0] v);
    send_word(OP_ENCODE, 8'($urandom_range(255)), v);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(7))
      0: v = 64'($urandom_range(63));
      1: v = 64'($urandom_range(16383));
      2: v = {34'd0, v[29:0]};
      3, 4: v = {2'b00, v[61:0]};
      5: ;
      6: begin
        case ($urandom_range(7))
          0: v = 64'd63;
          1: v = 64'd64;
          2: v = 64'd16383;
          3: v = 64'd16384;
          4: v = 64'h3FFF_FFFF;
          5: v = 64'h4000_0000;
          6: v = 64'h3FFF_FFFF_FFFF_FFFF;
          default: v = 64'h4000_0000_0000_0000;
        endcase
      end
      default: v = {2'b00, v[61:0]} >> $urandom_range(61);
    endcase
    return v;
  endfunction

  // one well-formed decode run, now and then with an encode word slipped in mid-run
  task automatic send_decode_run();
    logic [1:0] tag;
    int         run_bytes;
    int         split_at;
    tag       = 2'($urandom_range(3));
    run_bytes = 1 << tag;
    split_at  = 0;
    if (run_bytes > 1 && $urandom_range(9) == 0) split_at = $urandom_range(run_bytes - 1, 1);
    for (int i = 0; i < run_bytes; i++) begin
      if (split_at != 0 && i == split_at) send_value(pick_value());
      if (i == 0) begin
        send_byte({tag, 6'($urandom_range(63))});
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_traffic(input int count);
    int target;
    int pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_decode_run();
      end else if (pick < 90) begin
        send_value(pick_value());
      end else begin
        // stray byte that may break run alignment
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_DECODE;
    in_ch.byte_in  <= '0;
    in_ch.value_in <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-byte runs at both ends, largest two-byte run
    send_byte(8'h00);
    send_byte(LOW_SIX_MASK);
    send_byte(8'h7F);
    send_byte(8'hFF);
    // non-minimal four-byte run with an encode word in the middle
    send_byte(8'h80);
    send_byte(8'h00);
    send_value(64'h2A);
    send_byte(8'h00);
    send_byte(8'h25);
    // largest eight-byte run
    repeat (8) send_byte(8'hFF);
    // encode around every length boundary, and values too large
    send_value(64'd0);
    send_value(64'd63);
    send_value(64'd64);
    send_value(64'd16383);
    send_value(64'd16384);
    send_value(64'h3FFF_FFFF);
    send_value(64'h4000_0000);
    send_value(64'h3FFF_FFFF_FFFF_FFFF);
    send_value(64'h4000_0000_0000_0000);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    wait_results_drained();

    // long receiver hold-off while the sender keeps offering words
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    run_traffic(PHASE_ITEMS);
    wait_results_drained();

    idle_pct = 60;
    run_traffic(PHASE_ITEMS);
    wait_results_drained();

    idle_pct = 0;
    stall_pct <= 60;
    run_traffic(PHASE_ITEMS);
    wait_results_drained();

    idle_pct = 37;
    stall_pct <= 37;
    run_traffic(PHASE_ITEMS);
    wait_results_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && results_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
